### rtl/sbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the serial bootloader sequencer.
// No dependencies; imported by every other file of the block.
package sbs_pkg;

  localparam int unsigned ADDR_W       = 17;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned ROW_WORDS_DEF = 64;
  localparam int unsigned MAX_RES      = 3;
  localparam int unsigned FIFO_DEPTH   = 2;

  localparam logic [7:0]        SYNC_FIRST   = 8'h55;
  localparam logic [7:0]        SYNC_SECOND  = 8'hAA;
  localparam logic [7:0]        TIMEOUT_RST  = 8'd186;
  localparam logic [7:0]        RETRY_RST    = 8'd3;
  localparam logic [ADDR_W-1:0] REG_START_RST = 17'h00900;
  localparam logic [ADDR_W-1:0] REG_END_RST  = 17'h1FFFF;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_RETRY   = 2'd1,
    CFG_START   = 2'd2,
    CFG_END     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    K_WORD        = 4'd0,
    K_COMMIT      = 4'd1,
    K_ERASE       = 4'd2,
    K_ACK         = 4'd3,
    K_INIT        = 4'd4,
    K_HS_TIMEOUT  = 4'd5,
    K_PKT_TIMEOUT = 4'd6,
    K_END         = 4'd7,
    K_ERROR       = 4'd8
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } result_t;

  // Results caused by one input transaction, emitted in index order.
  typedef struct packed {
    logic [1:0]              cnt;
    result_t [MAX_RES-1:0]   res;
  } bundle_t;

endpackage

### rtl/serial_bootloader_sequencer.sv
`timescale 1ns / 1ps
// Serial bootloader sequencer top level: front end, bundle queue, emitter.
// Depends on sbs_pkg, sbs_front, sbs_fifo, sbs_back.
// Path: the first result of an input is registered in the bundle queue, then in the output register.
// Throughput: one input per cycle while the 2-entry bundle queue has room;
// the emitter drains one result per cycle while the output is not stalled.
// Reset: asynchronous active low; protocol returns to handshake wait and
// configuration registers take their default values.
module serial_bootloader_sequencer #(
  parameter int unsigned ROW_WORDS = sbs_pkg::ROW_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
  input  logic                       s_axis_tuser,  // [0] mode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,  // [16:0] target_address, [32:17] word_value
  output logic [3:0]                 m_axis_tuser,  // [3:0] kind
  output logic                       m_axis_tlast,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [sbs_pkg::ADDR_W-1:0] cfg_wdata_i
);
  import sbs_pkg::*;

  logic              push_valid, push_ready, head_valid, pop;
  bundle_t           push_data, head_data;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] word;

  sbs_front #(.ROW_WORDS(ROW_WORDS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .rx_byte_i    (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_data_o  (head_data)
  );

  sbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .kind_o       (m_axis_tuser),
    .addr_o       (addr),
    .word_o       (word),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, word, addr};

endmodule

### rtl/sbs_front.sv
`timescale 1ns / 1ps
// Front end: accepts byte/tick transactions, runs the bootloader protocol
// state and pushes the resulting bundle of results. Depends on sbs_pkg.
module sbs_front #(
  parameter int unsigned ROW_WORDS = sbs_pkg::ROW_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     mode_i,
  input  logic [7:0]               rx_byte_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [sbs_pkg::ADDR_W-1:0] cfg_wdata_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output sbs_pkg::bundle_t         push_data_o
);
  import sbs_pkg::*;

  localparam logic [7:0] ROW_BYTES = 8'(2 * ROW_WORDS);

  phase_e            phase_q, phase_d;
  logic [7:0]        prev_q, prev_d;
  logic [7:0]        tick_q, tick_d;
  logic [7:0]        retry_q, retry_d;
  logic [ADDR_W-1:0] row_q, row_d;
  logic [6:0]        bidx_q, bidx_d;
  logic [7:0]        low_q, low_d;

  logic [7:0]        timeout_q, limit_q;
  logic [ADDR_W-1:0] rstart_q, rend_q;

  logic              accept;
  logic [7:0]        tick_inc, retry_inc;
  logic              tick_hit, sync_hit, retry_err, row_done, end_hit;
  logic [6:0]        bidx_inc;
  logic [ADDR_W-1:0] row_base, word_addr;
  logic [ADDR_W:0]   next_row;
  logic [ADDR_W+1:0] next_last;
  bundle_t           bundle;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign tick_inc  = tick_q + 8'd1;
  assign tick_hit  = tick_inc >= timeout_q;
  assign sync_hit  = (prev_q == SYNC_FIRST) && (rx_byte_i == SYNC_SECOND);
  assign retry_inc = (retry_q != 8'hFF) ? retry_q + 8'd1 : retry_q;
  assign retry_err = retry_inc >= limit_q;
  assign bidx_inc  = bidx_q + 7'd1;
  assign row_done  = ({1'b0, bidx_inc} >= ROW_BYTES) || (bidx_inc == 7'd0);
  assign row_base  = {row_q[ADDR_W-1:7], 7'd0};
  assign word_addr = row_base + {10'd0, bidx_q[6:1], 1'b0};
  assign next_row  = {1'b0, row_q} + {10'd0, ROW_BYTES};
  // Compared without wrapping so running off the top always ends the write.
  assign next_last = {1'b0, next_row} + {11'd0, ROW_BYTES - 8'd1};
  assign end_hit   = next_last > {2'b00, rend_q};

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        PH_WAIT: begin
          if (mode_i && tick_hit) phase_d = PH_DONE;
          else if (!mode_i && sync_hit) phase_d = PH_RECV;
        end
        PH_RECV: begin
          if (mode_i && tick_hit && retry_err) phase_d = PH_DONE;
          else if (!mode_i && row_done && end_hit) phase_d = PH_DONE;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Datapath state and result bundle
  always_comb begin
    prev_d  = prev_q;
    tick_d  = tick_q;
    retry_d = retry_q;
    row_d   = row_q;
    bidx_d  = bidx_q;
    low_d   = low_q;
    bundle  = '0;
    for (int i = 0; i < MAX_RES; i++) bundle.res[i].kind = K_ACK;
    case (phase_q)
      PH_WAIT: begin
        if (mode_i) begin
          tick_d = tick_hit ? 8'd0 : tick_inc;
          if (tick_hit) begin
            bundle.cnt         = 2'd1;
            bundle.res[0].kind = K_HS_TIMEOUT;
          end
        end else begin
          prev_d = rx_byte_i;
          if (sync_hit) begin
            bundle.cnt         = 2'd3;
            bundle.res[0].kind = K_INIT;
            bundle.res[1].kind = K_ERASE;
            bundle.res[1].addr = rstart_q;
            bundle.res[2].kind = K_ACK;
            row_d   = rstart_q;
            bidx_d  = 7'd0;
            retry_d = 8'd0;
            tick_d  = 8'd0;
          end
        end
      end
      PH_RECV: begin
        if (mode_i) begin
          tick_d = tick_hit ? 8'd0 : tick_inc;
          if (tick_hit) begin
            bidx_d             = 7'd0;
            retry_d            = retry_inc;
            bundle.cnt         = 2'd2;
            bundle.res[0].kind = K_PKT_TIMEOUT;
            bundle.res[1].kind = retry_err ? K_ERROR : K_ACK;
          end
        end else begin
          tick_d = 8'd0;
          bidx_d = bidx_inc;
          if (!bidx_q[0]) begin
            low_d = rx_byte_i;
          end else begin
            bundle.cnt         = 2'd1;
            bundle.res[0].kind = K_WORD;
            bundle.res[0].addr = word_addr;
            bundle.res[0].word = {rx_byte_i, low_q};
          end
          if (row_done) begin
            bidx_d  = 7'd0;
            retry_d = 8'd0;
            row_d   = next_row[ADDR_W-1:0];
            // Commit and ack/end follow the word latch when there is one.
            if (bidx_q[0]) begin
              bundle.cnt         = 2'd3;
              bundle.res[1].kind = K_COMMIT;
              bundle.res[1].addr = row_base;
              bundle.res[2].kind = end_hit ? K_END : K_ACK;
            end else begin
              bundle.cnt         = 2'd2;
              bundle.res[0].kind = K_COMMIT;
              bundle.res[0].addr = row_base;
              bundle.res[1].kind = end_hit ? K_END : K_ACK;
            end
          end
        end
      end
      default: bundle.cnt = 2'd0;
    endcase
  end

  assign push_valid_o = accept && (bundle.cnt != 2'd0);
  assign push_data_o  = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      prev_q  <= '0;
      tick_q  <= '0;
      retry_q <= '0;
      row_q   <= '0;
      bidx_q  <= '0;
      low_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      tick_q  <= tick_d;
      retry_q <= retry_d;
      row_q   <= row_d;
      bidx_q  <= bidx_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      limit_q   <= RETRY_RST;
      rstart_q  <= REG_START_RST;
      rend_q    <= REG_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i[7:0];
        CFG_RETRY:   limit_q   <= cfg_wdata_i[7:0];
        CFG_START:   rstart_q  <= cfg_wdata_i;
        CFG_END:     rend_q    <= cfg_wdata_i;
        default:     timeout_q <= timeout_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("finished phase left without reset");

  a_no_push_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !push_valid_o)
    else $error("result produced after finish");
`endif

endmodule

### rtl/sbs_fifo.sv
`timescale 1ns / 1ps
// Short bundle queue decoupling the front end from the result emitter.
// Depends on sbs_pkg.
module sbs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  sbs_pkg::bundle_t push_data_i,
  output logic             head_valid_o,
  input  logic             pop_i,
  output sbs_pkg::bundle_t head_data_o
);
  import sbs_pkg::*;

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(FIFO_DEPTH - 1);

  bundle_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != DEPTH_C;
  assign head_valid_o = cnt_q != '0;
  assign head_data_o  = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & head_valid_o;

  always_comb begin
    wr_d  = push ? ((wr_q == LAST_C) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == LAST_C) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("queue occupancy out of range");
`endif

endmodule

### rtl/sbs_back.sv
`timescale 1ns / 1ps
// Back end: walks the head bundle into the output register one result
// per cycle unless stalled; pops it after its final result. Needs sbs_pkg.
module sbs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  sbs_pkg::bundle_t           head_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 kind_o,
  output logic [sbs_pkg::ADDR_W-1:0] addr_o,
  output logic [sbs_pkg::WORD_W-1:0] word_o,
  output logic                       last_o
);
  import sbs_pkg::*;

  logic       vld_q, vld_d;
  result_t    res_q, res_d;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;
  logic       load, is_last;

  assign load    = head_valid_i && (!vld_q || out_ready_i);
  assign is_last = idx_q == (head_data_i.cnt - 2'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    vld_d  = vld_q;
    res_d  = res_q;
    last_d = last_q;
    idx_d  = idx_q;
    if (load) begin
      vld_d  = 1'b1;
      res_d  = head_data_i.res[idx_q];
      last_d = is_last;
      idx_d  = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = res_q.kind;
  assign addr_o      = res_q.addr;
  assign word_o      = res_q.word;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < head_data_i.cnt)
    else $error("result index past bundle size");
`endif

endmodule

### test/tb_serial_bootloader_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for serial_bootloader_sequencer: random stream of bytes and ticks
// through handshake, row loading, retries and the end of an update. Needs rtl/sbs_pkg.sv.
module tb_serial_bootloader_sequencer;
  import sbs_pkg::*;

  localparam int unsigned ROW_BYTES   = 2 * ROW_WORDS_DEF;
  localparam logic [ADDR_W-1:0] ROW_MASK = 17'h1FF80;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx;
  } serial_evt_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              is_last;
  } seq_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // [7:0] rx_byte
  logic              s_axis_tuser = 1'b0; // [0] mode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;        // [16:0] target_address, [32:17] word_value
  logic [3:0]        m_axis_tuser;        // [3:0] kind
  logic              m_axis_tlast;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [ADDR_W-1:0] cfg_wdata_i = '0;

  serial_bootloader_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Loader mirror: registers and protocol state
  logic [7:0]        ld_timeout;
  logic [7:0]        ld_retry_lim;
  logic [ADDR_W-1:0] ld_region_start;
  logic [ADDR_W-1:0] ld_region_end;
  phase_e            ld_phase;
  logic [7:0]        ld_prev_byte;
  logic [7:0]        ld_ticks;
  logic [7:0]        ld_retries;
  logic [ADDR_W-1:0] ld_row_addr;
  logic [6:0]        ld_byte_idx;
  logic [7:0]        ld_low_byte;

  serial_evt_t evt_feed[$];
  seq_out_t    due_records[$];
  seq_out_t    step_batch[$];

  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned fed_items = 0;
  int unsigned cyc_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic        in_fire = 1'b0;
  logic        calm;

  // stretches in which no new random gaps are started on either side
  assign calm = (cyc_cnt % 700) < 200;

  function automatic void loader_clear();
    ld_timeout      = TIMEOUT_RST;
    ld_retry_lim    = RETRY_RST;
    ld_region_start = REG_START_RST;
    ld_region_end   = REG_END_RST;
    ld_phase        = PH_WAIT;
    ld_prev_byte    = '0;
    ld_ticks        = '0;
    ld_retries      = '0;
    ld_row_addr     = '0;
    ld_byte_idx     = '0;
    ld_low_byte     = '0;
  endfunction

  function automatic void note_result(input kind_e k, input logic [ADDR_W-1:0] a,
                                      input logic [WORD_W-1:0] w);
    seq_out_t r;
    r.kind    = k;
    r.addr    = a;
    r.word    = w;
    r.is_last = 1'b0;
    step_batch.push_back(r);
  endfunction

  // One byte or tick through the loader protocol; appends what it reports.
  function automatic void loader_advance(input logic mode, input logic [7:0] rx);
    logic [ADDR_W-1:0] base;
    int unsigned       nxt;
    step_batch.delete();
    base = ld_row_addr & ROW_MASK;
    case (ld_phase)
      PH_WAIT: begin
        if (mode) begin
          ld_ticks = ld_ticks + 8'd1;
          if (ld_ticks >= ld_timeout) begin
            ld_ticks = '0;
            ld_phase = PH_DONE;
            note_result(K_HS_TIMEOUT, '0, '0);
          end
        end else if (ld_prev_byte == SYNC_FIRST && rx == SYNC_SECOND) begin
          note_result(K_INIT, '0, '0);
          note_result(K_ERASE, ld_region_start, '0);
          note_result(K_ACK, '0, '0);
          ld_phase     = PH_RECV;
          ld_row_addr  = ld_region_start;
          ld_byte_idx  = '0;
          ld_retries   = '0;
          ld_ticks     = '0;
          ld_prev_byte = rx;
        end else begin
          ld_prev_byte = rx;
        end
      end
      PH_RECV: begin
        if (mode) begin
          ld_ticks = ld_ticks + 8'd1;
          if (ld_ticks >= ld_timeout) begin
            ld_ticks    = '0;
            ld_byte_idx = '0;
            note_result(K_PKT_TIMEOUT, '0, '0);
            if (ld_retries != 8'hFF) ld_retries = ld_retries + 8'd1;
            if (ld_retries >= ld_retry_lim) begin
              ld_phase = PH_DONE;
              note_result(K_ERROR, '0, '0);
            end else begin
              note_result(K_ACK, '0, '0);
            end
          end
        end else begin
          ld_ticks = '0;
          if (!ld_byte_idx[0]) ld_low_byte = rx;
          else note_result(K_WORD, base + {10'd0, ld_byte_idx[6:1], 1'b0}, {rx, ld_low_byte});
          ld_byte_idx = ld_byte_idx + 7'd1;
          // index wraps to zero exactly when the row is full
          if (ld_byte_idx == '0) begin
            ld_retries = '0;
            note_result(K_COMMIT, base, '0);
            nxt = ld_row_addr + ROW_BYTES;
            ld_row_addr = nxt[ADDR_W-1:0];
            // no wrap in the compare: running past the top always ends the write
            if (nxt + ROW_BYTES - 1 > ld_region_end) begin
              ld_phase = PH_DONE;
              note_result(K_END, '0, '0);
            end else begin
              note_result(K_ACK, '0, '0);
            end
          end
        end
      end
      default: ;
    endcase
    if (step_batch.size() > 0) step_batch[step_batch.size() - 1].is_last = 1'b1;
    foreach (step_batch[i]) due_records.push_back(step_batch[i]);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 7);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] data_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_start();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return 17'h1FFFF;
    return ADDR_W'($urandom_range(0, 17'h1FFFF));
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    evt_feed.push_back('{mode: 1'b0, rx: b});
    fed_items++;
  endfunction

  // rx carries noise on ticks; the block must ignore it
  function automatic void queue_ticks(input int unsigned n);
    repeat (n) begin
      evt_feed.push_back('{mode: 1'b1, rx: 8'($urandom_range(0, 255))});
      fed_items++;
    end
  endfunction

  // Everything accepted and reported, plus room for result-less items still in flight
  task automatic settle();
    while (evt_feed.size() != 0 || s_axis_tvalid || due_records.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ADDR_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_TIMEOUT: ld_timeout      = val[7:0];
      CFG_RETRY:   ld_retry_lim    = val[7:0];
      CFG_START:   ld_region_start = val;
      CFG_END:     ld_region_end   = val;
      default: ;
    endcase
  endtask

  // Input driver
  serial_evt_t feed_cur;
  logic        feed_valid_nx;
  int unsigned feed_gap = 0;

  always @(negedge clk_i) begin
    feed_valid_nx = s_axis_tvalid;
    if (in_fire) begin
      feed_valid_nx = 1'b0;
      if (!calm && $urandom_range(0, 2) == 0) feed_gap = gap_len();
    end
    if (!feed_valid_nx && rst_ni) begin
      if (feed_gap > 0) begin
        feed_gap--;
      end else if (evt_feed.size() > 0) begin
        feed_cur      = evt_feed.pop_front();
        feed_valid_nx = 1'b1;
        s_axis_tuser <= feed_cur.mode;
        s_axis_tdata <= feed_cur.rx;
      end
    end
    s_axis_tvalid <= feed_valid_nx;
  end

  // Result receiver: random stalls plus one long hold-off to back up the block
  int unsigned drain_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) drain_gap = gap_len();
    end
  end

  // Monitor: predict on input transactions, check output transactions
  seq_out_t want;

  always @(posedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) loader_advance(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_records.size() == 0) begin
        $error("result with none due: kind %0d, address 'h%0h", m_axis_tuser,
               m_axis_tdata[16:0]);
        fail_count++;
      end else begin
        want = due_records.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[16:0] !== want.addr) begin
          $error("target_address: expected 'h%05h, got 'h%05h", want.addr, m_axis_tdata[16:0]);
          fail_count++;
        end
        if (m_axis_tdata[32:17] !== want.word) begin
          $error("word_value: expected 'h%04h, got 'h%04h", want.word, m_axis_tdata[32:17]);
          fail_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** serial_bootloader_sequencer: FAILED **");
      $finish;
    end
  end

  initial begin
    logic              high_start;
    logic [ADDR_W-1:0] start_addr;
    int unsigned       attempt;
    int unsigned       broken_run;
    int unsigned       lim;
    loader_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // a start near the top of flash runs into the end of the address space
    high_start = ($urandom_range(0, 3) == 0);
    if (high_start)
      start_addr = 17'h1FF00 + ($urandom_range(0, 1) ? 17'd0 : 17'($urandom_range(1, 127)));
    else
      start_addr = 17'($urandom_range(0, 17'h1F000));
    write_reg(CFG_TIMEOUT, 17'd4);
    write_reg(CFG_RETRY, 17'd255);
    write_reg(CFG_START, start_addr);
    write_reg(CFG_END, 17'h1FFFF);

    // ticks keep counting across bytes while waiting; a tick between the sync bytes is fine
    queue_ticks(2);
    queue_byte(SYNC_FIRST);
    queue_byte(8'h13);
    queue_byte(SYNC_SECOND);
    queue_byte(SYNC_FIRST);
    queue_ticks(1);
    queue_byte(SYNC_SECOND);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_ticks(4);
    write_reg(CFG_TIMEOUT, 17'd1);
    queue_ticks(1);

    // rows with random content, ticks between bytes, some dropped by a timeout
    write_reg(CFG_TIMEOUT, 17'($urandom_range(2, 12)));
    fed_items  = 0;
    attempt    = 0;
    broken_run = 0;
    while (ld_phase == PH_RECV && (high_start || fed_items < 100)) begin
      if (attempt == 2)
        write_reg(CFG_TIMEOUT, 17'd255);
      else if (attempt == 3 || (attempt > 3 && $urandom_range(0, 2) == 0))
        write_reg(CFG_TIMEOUT, 17'($urandom_range(2, 12)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_RETRY, 17'($urandom_range(8, 255)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_START, pick_start());
      if (broken_run < 2 && ld_timeout <= 16 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 50)) queue_byte(data_byte());
        queue_ticks(ld_timeout);
        broken_run++;
      end else begin
        lim = (ld_timeout > 13) ? 12 : ld_timeout - 1;
        repeat (ROW_BYTES - ld_byte_idx) begin
          if (lim > 0 && $urandom_range(0, 11) == 0) queue_ticks($urandom_range(1, lim));
          queue_byte(data_byte());
        end
        broken_run = 0;
      end
      settle();
      attempt++;
    end

    // close the update: error on the first timeout, or end after the current row
    write_reg(CFG_RETRY, 17'd1);
    write_reg(CFG_END, 17'd0);
    if (ld_phase == PH_RECV) begin
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_TIMEOUT, 17'd1);
        queue_byte(data_byte());
        queue_ticks(1);
      end else begin
        repeat (ROW_BYTES - ld_byte_idx) queue_byte(data_byte());
      end
    end
    settle();

    // finished: nothing more may be reported
    queue_ticks(2);
    queue_byte(SYNC_FIRST);
    queue_byte(SYNC_SECOND);
    settle();
    repeat (16) @(posedge clk_i);

    if (fail_count == 0)
      $display("** serial_bootloader_sequencer: PASSED **");
    else
      $display("** serial_bootloader_sequencer: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/sbs_pkg.sv
rtl/sbs_front.sv
rtl/sbs_fifo.sv
rtl/sbs_back.sv
rtl/serial_bootloader_sequencer.sv
test/tb_serial_bootloader_sequencer.sv
